### rtl/core/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

    // Length codes in the second header byte that call for an extended length
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Last byte index of each multi-byte header field
    localparam logic [2:0] EXT16_LAST_IDX = 3'd1;
    localparam logic [2:0] EXT64_LAST_IDX = 3'd7;
    localparam logic [2:0] KEY_LAST_IDX   = 3'd3;

    // Depth of the result buffer
    localparam int OBUF_DEPTH = 2;
    localparam int OBUF_PTR_W = (OBUF_DEPTH > 1) ? $clog2(OBUF_DEPTH) : 1;
    localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

    // One deframed result
    typedef struct packed {
        logic [3:0]  opcode;
        logic [7:0]  payload_byte;
        logic        has_payload;
        logic        last_of_frame;
        logic [63:0] frame_length;
    } wsd_result_t;

endpackage

### rtl/core/wsd_out_fifo.sv
`timescale 1ns / 1ps

module wsd_out_fifo
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  wsd_result_t push_data,
    output logic        full,
    output logic        out_valid,
    input  logic        out_ready,
    output wsd_result_t out_data
);

    wsd_result_t           mem_reg [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0] wr_ptr_reg;
    logic [OBUF_PTR_W-1:0] rd_ptr_reg;
    logic [OBUF_CNT_W-1:0] count_reg;
    logic [OBUF_PTR_W-1:0] wr_ptr_next;
    logic [OBUF_PTR_W-1:0] rd_ptr_next;
    logic [OBUF_CNT_W-1:0] count_next;
    logic                  pop;

    localparam logic [OBUF_CNT_W-1:0] DEPTH_CNT = OBUF_CNT_W'(OBUF_DEPTH);
    localparam logic [OBUF_PTR_W-1:0] LAST_PTR  = OBUF_PTR_W'(OBUF_DEPTH - 1);

    assign full      = (count_reg == DEPTH_CNT);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store result entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// -------   --------------------   ------------------------------------------------
// input     in_valid / in_ready    rx_byte
// output    out_valid / out_ready  opcode, payload_byte, has_payload,
//                                  last_of_frame, frame_length
//
// One byte per cycle while in_ready is high: each accepted byte updates the
// header/payload state and, when it yields a result, writes it into a
// two-entry output buffer, where it waits behind earlier entries for the output.
// in_ready drops only while both buffer entries wait on out_ready.
// rst_n (asynchronous, active low) returns the parser to the first header byte.

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  opcode,
    output logic [7:0]  payload_byte,
    output logic        has_payload,
    output logic        last_of_frame,
    output logic [63:0] frame_length
);

    localparam logic [2:0] PH_HDR0  = 3'd0;
    localparam logic [2:0] PH_HDR1  = 3'd1;
    localparam logic [2:0] PH_EXT16 = 3'd2;
    localparam logic [2:0] PH_EXT64 = 3'd3;
    localparam logic [2:0] PH_KEY   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;

    logic [2:0]  phase_reg,        phase_next;
    logic [3:0]  opcode_reg,       opcode_next;
    logic        mask_reg,         mask_next;
    logic [63:0] length_reg,       length_next;
    logic [2:0]  hdr_cnt_reg,      hdr_cnt_next;
    logic [31:0] key_reg,          key_next;
    logic [63:0] remaining_reg,    remaining_next;
    logic [1:0]  key_lane_reg,     key_lane_next;

    logic        accept;
    logic        fifo_full;
    logic        res_push;
    wsd_result_t res_data;
    wsd_result_t out_data;
    logic [63:0] length_shift;
    logic [6:0]  len_code;
    logic [7:0]  key_byte;

    assign in_ready     = !fifo_full;
    assign accept       = in_valid && in_ready;
    assign length_shift = {length_reg[55:0], rx_byte};
    assign len_code     = rx_byte[6:0];

    // Select the key byte for the current payload lane
    always_comb
    begin
        case (key_lane_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Advance the frame parser by one byte
    always_comb
    begin
        phase_next     = phase_reg;
        opcode_next    = opcode_reg;
        mask_next      = mask_reg;
        length_next    = length_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        key_next       = key_reg;
        remaining_next = remaining_reg;
        key_lane_next  = key_lane_reg;
        res_push       = 1'b0;
        res_data.opcode        = opcode_reg;
        res_data.payload_byte  = 8'd0;
        res_data.has_payload   = 1'b0;
        res_data.last_of_frame = 1'b1;
        res_data.frame_length  = length_reg;

        if (accept)
        begin
            unique case (phase_reg) inside
                PH_HDR0:
                begin
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    mask_next    = rx_byte[7];
                    key_next     = '0;
                    hdr_cnt_next = '0;
                    if (len_code == LEN_CODE_EXT16)
                    begin
                        length_next = '0;
                        phase_next  = PH_EXT16;
                    end
                    else if (len_code == LEN_CODE_EXT64)
                    begin
                        length_next = '0;
                        phase_next  = PH_EXT64;
                    end
                    else
                    begin
                        // Short length: header ends here unless a key follows
                        length_next    = {57'd0, len_code};
                        remaining_next = {57'd0, len_code};
                        key_lane_next  = '0;
                        res_data.frame_length = {57'd0, len_code};
                        if (rx_byte[7])
                        begin
                            phase_next = PH_KEY;
                        end
                        else if (len_code == 7'd0)
                        begin
                            res_push   = 1'b1;
                            phase_next = PH_HDR0;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    length_next = length_shift;
                    if ((phase_reg == PH_EXT16 && hdr_cnt_reg == EXT16_LAST_IDX) ||
                        (phase_reg == PH_EXT64 && hdr_cnt_reg == EXT64_LAST_IDX))
                    begin
                        hdr_cnt_next   = '0;
                        remaining_next = length_shift;
                        key_lane_next  = '0;
                        res_data.frame_length = length_shift;
                        if (mask_reg)
                        begin
                            phase_next = PH_KEY;
                        end
                        else if (length_shift == 64'd0)
                        begin
                            res_push   = 1'b1;
                            phase_next = PH_HDR0;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (hdr_cnt_reg == KEY_LAST_IDX)
                    begin
                        hdr_cnt_next = '0;
                        if (length_reg == 64'd0)
                        begin
                            res_push   = 1'b1;
                            phase_next = PH_HDR0;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    end
                end
                PH_DATA:
                begin
                    // Unmask one payload byte
                    remaining_next         = remaining_reg - 64'd1;
                    key_lane_next          = key_lane_reg + 2'd1;
                    res_push               = 1'b1;
                    res_data.payload_byte  = rx_byte ^ key_byte;
                    res_data.has_payload   = 1'b1;
                    res_data.last_of_frame = (remaining_reg == 64'd1);
                    if (remaining_reg == 64'd1)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            opcode_reg    <= '0;
            mask_reg      <= 1'b0;
            length_reg    <= '0;
            hdr_cnt_reg   <= '0;
            key_reg       <= '0;
            remaining_reg <= '0;
            key_lane_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            opcode_reg    <= opcode_next;
            mask_reg      <= mask_next;
            length_reg    <= length_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            key_reg       <= key_next;
            remaining_reg <= remaining_next;
            key_lane_reg  <= key_lane_next;
        end
    end

    // Hold results until the consumer takes the transaction
    wsd_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .full      (fifo_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign opcode        = out_data.opcode;
    assign payload_byte  = out_data.payload_byte;
    assign has_payload   = out_data.has_payload;
    assign last_of_frame = out_data.last_of_frame;
    assign frame_length  = out_data.frame_length;

endmodule
